[hdl/ows_pkg.sv]
package ows_pkg;

	localparam int unsigned STORE_DEPTH = 11;
	localparam int unsigned IDX_W       = 4;
	localparam int unsigned ROM_BYTES   = 8;
	localparam int unsigned ROM_BASE    = 0;
	localparam int unsigned FUNC_BASE   = 8;

	localparam logic [1:0] REQ_START = 2'd0;
	localparam logic [1:0] REQ_LOAD  = 2'd1;
	localparam logic [1:0] REQ_ECHO  = 2'd2;

	localparam logic [7:0] SLOT_RESET = 8'hF0;
	localparam logic [7:0] SLOT_ONE   = 8'hFF;
	localparam logic [7:0] SLOT_ZERO  = 8'h00;

	localparam logic [7:0] CMD_READ_ROM  = 8'h33;
	localparam logic [7:0] CMD_MATCH_ROM = 8'h55;
	localparam logic [7:0] CMD_WRITE_SP  = 8'h4E;
	localparam logic [7:0] CMD_READ_SP   = 8'hBE;

	localparam logic [3:0] WRITE_SP_BYTES = 4'd3;
	localparam logic [3:0] READ_SP_BYTES  = 4'd9;

	typedef struct packed {
		logic [1:0]       req_type;
		logic [7:0]       rom_cmd_byte;
		logic [7:0]       func_cmd_byte;
		logic [IDX_W-1:0] load_index;
		logic [7:0]       data_byte;
		logic [7:0]       echo_byte;
	} item_t;

	typedef struct packed {
		logic       send_valid;
		logic [7:0] send_byte;
		logic       reset_speed;
		logic       read_valid;
		logic [7:0] read_byte;
		logic       read_from_function;
		logic [3:0] read_index;
		logic       done_res;
		logic       no_device;
	} res_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
		logic [7:0]       data;
	} store_wr_t;

endpackage

[hdl/onewire_uart_transaction_sequencer.sv]
// the result transaction is registered in the core's res_q after its input transaction passes the item_s1 register
// throughput: one transaction per cycle while m_tready holds no result back, set by the sequencer update
// a result held back by m_tready stalls the input, two transactions can be in flight
// transactions that cause no result leave the output empty
// reset: asynchronous active-low arst_n clears phase, counters, commands and valids
// the write-data store is not cleared and holds nothing until loaded
module onewire_uart_transaction_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// rom_cmd_byte, func_cmd_byte, load_index, data_byte, echo_byte, zero fill
	input  logic [39:0] s_tdata,
	// req_type
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// send_valid, send_byte, reset_speed, read_valid, read_byte,
	// read_from_function, read_index, done_res, no_device, zero fill
	output logic [31:0] m_tdata
);

	logic            valid_s1;
	ows_pkg::item_t  item_s1;
	logic            core_ready;
	logic            res_valid;
	ows_pkg::res_t   res;

	assign s_tready = !valid_s1 || core_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.req_type      <= s_tuser;
			item_s1.rom_cmd_byte  <= s_tdata[7:0];
			item_s1.func_cmd_byte <= s_tdata[15:8];
			item_s1.load_index    <= s_tdata[19:16];
			item_s1.data_byte     <= s_tdata[27:20];
			item_s1.echo_byte     <= s_tdata[35:28];
		end
	end

	ows_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_item   (item_s1),
		.in_ready  (core_ready),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (m_tready)
	);

	assign m_tvalid = res_valid;
	assign m_tdata  = {6'd0, res.no_device, res.done_res, res.read_index,
		res.read_from_function, res.read_byte, res.read_valid, res.reset_speed,
		res.send_byte, res.send_valid};

endmodule

[hdl/ows_store.sv]
module ows_store #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = ows_pkg::STORE_DEPTH
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hdl/ows_core.sv]
module ows_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  ows_pkg::item_t        in_item,
	output logic                  in_ready,
	output logic                  res_valid,
	output ows_pkg::res_t         res,
	input  logic                  res_ready
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_PRESENCE,
		PH_ROM_CMD,
		PH_ROM_DATA,
		PH_FUNC_CMD,
		PH_FUNC_DATA
	} phase_t;

	phase_t     phase_q, phase_d;
	logic [2:0] bit_q, bit_d;
	logic [3:0] byte_q, byte_d;
	logic [7:0] rom_q, rom_d;
	logic [7:0] func_q, func_d;
	logic [7:0] shift_q, shift_d;

	logic          res_valid_q;
	ows_pkg::res_t res_q;
	logic          has_res;
	ows_pkg::res_t res_d;
	logic          emit_slot;
	logic          take;
	logic          store_slot;
	logic          store_slot_q;
	logic          rd_en;

	ows_pkg::store_wr_t          wr;
	logic [ows_pkg::IDX_W-1:0]   rd_idx;
	logic [7:0]                  rd_data;

	logic       rom_has_data;
	logic       func_has_data;
	logic       reading;
	logic [3:0] cur_len;
	logic [3:0] byte_inc;
	logic [7:0] src;

	assign take     = in_valid && in_ready;
	assign in_ready = !res_valid_q || res_ready;

	assign wr.en   = take && (in_item.req_type == ows_pkg::REQ_LOAD) &&
		(32'(in_item.load_index) < ows_pkg::STORE_DEPTH);
	assign wr.idx  = in_item.load_index;
	assign wr.data = in_item.data_byte;
	assign rd_en   = take && store_slot;

	ows_store #(
		.WIDTH (8),
		.DEPTH (ows_pkg::STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (wr.en),
		.waddr (wr.idx),
		.wdata (wr.data),
		.re    (rd_en),
		.raddr (rd_idx),
		.rdata (rd_data)
	);

	assign rom_has_data  = (rom_q == ows_pkg::CMD_READ_ROM) || (rom_q == ows_pkg::CMD_MATCH_ROM);
	assign func_has_data = (func_q == ows_pkg::CMD_WRITE_SP) || (func_q == ows_pkg::CMD_READ_SP);
	assign reading = ((phase_q == PH_ROM_DATA) && (rom_q == ows_pkg::CMD_READ_ROM)) ||
		((phase_q == PH_FUNC_DATA) && (func_q == ows_pkg::CMD_READ_SP));
	assign byte_inc = byte_q + 4'd1;

	always_comb begin
		case (phase_q)
			PH_ROM_DATA:  cur_len = 4'(ows_pkg::ROM_BYTES);
			PH_FUNC_DATA: cur_len = (func_q == ows_pkg::CMD_READ_SP) ?
				ows_pkg::READ_SP_BYTES : ows_pkg::WRITE_SP_BYTES;
			default:      cur_len = 4'd1;
		endcase
	end

	// next state and result of one transaction
	always_comb begin
		phase_d    = phase_q;
		bit_d      = bit_q;
		byte_d     = byte_q;
		rom_d      = rom_q;
		func_d     = func_q;
		shift_d    = shift_q;
		res_d      = '0;
		has_res    = 1'b0;
		emit_slot  = 1'b0;
		store_slot = 1'b0;
		case (in_item.req_type)
			ows_pkg::REQ_START: begin
				rom_d             = in_item.rom_cmd_byte;
				func_d            = in_item.func_cmd_byte;
				bit_d             = 3'd0;
				byte_d            = 4'd0;
				shift_d           = 8'h00;
				phase_d           = PH_PRESENCE;
				has_res           = 1'b1;
				res_d.send_valid  = 1'b1;
				res_d.send_byte   = ows_pkg::SLOT_RESET;
				res_d.reset_speed = 1'b1;
			end
			ows_pkg::REQ_ECHO: begin
				if (phase_q == PH_PRESENCE) begin
					has_res = 1'b1;
					if (in_item.echo_byte == ows_pkg::SLOT_RESET) begin
						phase_d         = PH_IDLE;
						res_d.no_device = 1'b1;
					end else begin
						phase_d   = PH_ROM_CMD;
						bit_d     = 3'd0;
						byte_d    = 4'd0;
						emit_slot = 1'b1;
					end
				end else if (phase_q != PH_IDLE) begin
					has_res   = 1'b1;
					emit_slot = 1'b1;
					if (reading) begin
						shift_d = {in_item.echo_byte == ows_pkg::SLOT_ONE, shift_q[7:1]};
					end
					if (bit_q != 3'd7) begin
						bit_d = bit_q + 3'd1;
					end else begin
						bit_d = 3'd0;
						if (reading) begin
							res_d.read_valid         = 1'b1;
							res_d.read_byte          = shift_d;
							res_d.read_from_function = (phase_q == PH_FUNC_DATA);
							res_d.read_index         = byte_q;
						end
						byte_d = byte_inc;
						if (byte_inc >= cur_len) begin
							byte_d = 4'd0;
							case (phase_q)
								PH_ROM_CMD:   phase_d = rom_has_data ? PH_ROM_DATA : PH_FUNC_CMD;
								PH_ROM_DATA:  phase_d = PH_FUNC_CMD;
								PH_FUNC_CMD:  phase_d = func_has_data ? PH_FUNC_DATA : PH_IDLE;
								default:      phase_d = PH_IDLE;
							endcase
							if (phase_d == PH_IDLE) begin
								emit_slot      = 1'b0;
								res_d.done_res = 1'b1;
							end
						end
					end
				end
			end
			default: begin
			end
		endcase
		if (emit_slot) begin
			res_d.send_valid = 1'b1;
			if (((phase_d == PH_ROM_DATA) && (rom_q == ows_pkg::CMD_READ_ROM)) ||
				((phase_d == PH_FUNC_DATA) && (func_q == ows_pkg::CMD_READ_SP))) begin
				res_d.send_byte = ows_pkg::SLOT_ONE;
			end else if ((phase_d == PH_ROM_DATA) || (phase_d == PH_FUNC_DATA)) begin
				// bit comes from the store read registered alongside the result
				store_slot = 1'b1;
			end else begin
				res_d.send_byte = src[bit_d] ? ows_pkg::SLOT_ONE : ows_pkg::SLOT_ZERO;
			end
		end
	end

	// bit source for the slot after this transaction
	always_comb begin
		rd_idx = (phase_d == PH_ROM_DATA) ? 4'(ows_pkg::ROM_BASE) + byte_d :
			4'(ows_pkg::FUNC_BASE) + byte_d;
		case (phase_d)
			PH_ROM_CMD:   src = rom_q;
			PH_FUNC_CMD:  src = func_q;
			default:      src = 8'h00;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			bit_q       <= 3'd0;
			byte_q      <= 4'd0;
			rom_q       <= 8'h00;
			func_q      <= 8'h00;
			shift_q     <= 8'h00;
			res_valid_q <= 1'b0;
		end else if (take) begin
			phase_q     <= phase_d;
			bit_q       <= bit_d;
			byte_q      <= byte_d;
			rom_q       <= rom_d;
			func_q      <= func_d;
			shift_q     <= shift_d;
			res_valid_q <= has_res;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q        <= res_d;
			store_slot_q <= store_slot;
		end
	end

	assign res_valid = res_valid_q;

	// bit_q holds the bit position of the slot in res_q
	always_comb begin
		res = res_q;
		if (store_slot_q) begin
			res.send_byte = rd_data[bit_q] ? ows_pkg::SLOT_ONE : ows_pkg::SLOT_ZERO;
		end
	end

endmodule

[tb/sv/testbench.sv]
module testbench;

	typedef enum logic [2:0] {
		SEQ_IDLE,
		SEQ_PRESENCE,
		SEQ_ROM_CMD,
		SEQ_ROM_BYTES,
		SEQ_FUNC_CMD,
		SEQ_FUNC_BYTES,
		SEQ_DONE
	} seq_phase_t;

	localparam logic [1:0] REQ_NONE = 2'd3;
	localparam int LATENCY = 2;

	class onewire_scoreboard;
		seq_phase_t     phase;
		logic [2:0]     bit_cnt;
		logic [3:0]     byte_cnt;
		logic [7:0]     rom_cmd;
		logic [7:0]     func_cmd;
		logic [7:0]     shift;
		logic [7:0]     store [ows_pkg::STORE_DEPTH];
		ows_pkg::res_t  expected_q [$];
		int             errors;
		int             checked;

		function new();
			phase    = SEQ_IDLE;
			bit_cnt  = '0;
			byte_cnt = '0;
			rom_cmd  = '0;
			func_cmd = '0;
			shift    = '0;
			errors   = 0;
			checked  = 0;
		endfunction

		function int span(seq_phase_t p);
			case (p)
				SEQ_ROM_CMD, SEQ_FUNC_CMD: return 1;
				SEQ_ROM_BYTES: return (rom_cmd == ows_pkg::CMD_READ_ROM ||
					rom_cmd == ows_pkg::CMD_MATCH_ROM) ? 8 : 0;
				SEQ_FUNC_BYTES: begin
					if (func_cmd == ows_pkg::CMD_WRITE_SP) return int'(ows_pkg::WRITE_SP_BYTES);
					if (func_cmd == ows_pkg::CMD_READ_SP) return int'(ows_pkg::READ_SP_BYTES);
					return 0;
				end
				default: return 0;
			endcase
		endfunction

		function bit reads(seq_phase_t p);
			return (p == SEQ_ROM_BYTES && rom_cmd == ows_pkg::CMD_READ_ROM) ||
				(p == SEQ_FUNC_BYTES && func_cmd == ows_pkg::CMD_READ_SP);
		endfunction

		function seq_phase_t following(seq_phase_t p);
			seq_phase_t q;
			q = seq_phase_t'(p + 1);
			while (q != SEQ_DONE && span(q) == 0)
				q = seq_phase_t'(q + 1);
			return q;
		endfunction

		function logic [7:0] slot();
			logic [7:0] src;
			src = '0;
			if (reads(phase))
				return ows_pkg::SLOT_ONE;
			case (phase)
				SEQ_ROM_CMD:    src = rom_cmd;
				SEQ_FUNC_CMD:   src = func_cmd;
				SEQ_ROM_BYTES:  src = store[ows_pkg::ROM_BASE + byte_cnt];
				SEQ_FUNC_BYTES: src = store[ows_pkg::FUNC_BASE + byte_cnt];
				default:        src = '0;
			endcase
			return src[bit_cnt] ? ows_pkg::SLOT_ONE : ows_pkg::SLOT_ZERO;
		endfunction

		function void note_input(ows_pkg::item_t it);
			ows_pkg::res_t r;
			bit            reading;
			r = '0;
			if (it.req_type == ows_pkg::REQ_LOAD) begin
				if (32'(it.load_index) < ows_pkg::STORE_DEPTH)
					store[it.load_index] = it.data_byte;
				return;
			end
			if (it.req_type == ows_pkg::REQ_START) begin
				rom_cmd       = it.rom_cmd_byte;
				func_cmd      = it.func_cmd_byte;
				bit_cnt       = '0;
				byte_cnt      = '0;
				shift         = '0;
				phase         = SEQ_PRESENCE;
				r.send_valid  = 1'b1;
				r.send_byte   = ows_pkg::SLOT_RESET;
				r.reset_speed = 1'b1;
				expected_q.push_back(r);
				return;
			end
			if (it.req_type != ows_pkg::REQ_ECHO || phase == SEQ_IDLE)
				return;
			if (phase == SEQ_PRESENCE) begin
				// unchanged reset slot: nobody pulled the line low
				if (it.echo_byte == ows_pkg::SLOT_RESET) begin
					phase       = SEQ_IDLE;
					r.no_device = 1'b1;
					expected_q.push_back(r);
					return;
				end
				phase    = SEQ_ROM_CMD;
				bit_cnt  = '0;
				byte_cnt = '0;
			end else begin
				reading = reads(phase);
				if (reading)
					shift = {it.echo_byte == ows_pkg::SLOT_ONE, shift[7:1]};
				if (bit_cnt != 3'd7) begin
					bit_cnt++;
				end else begin
					bit_cnt = '0;
					if (reading) begin
						r.read_valid         = 1'b1;
						r.read_byte          = shift;
						r.read_from_function = (phase == SEQ_FUNC_BYTES);
						r.read_index         = byte_cnt;
					end
					byte_cnt++;
					if (int'(byte_cnt) >= span(phase)) begin
						byte_cnt = '0;
						phase    = following(phase);
						if (phase == SEQ_DONE) begin
							phase     = SEQ_IDLE;
							r.done_res = 1'b1;
							expected_q.push_back(r);
							return;
						end
					end
				end
			end
			r.send_valid = 1'b1;
			r.send_byte  = slot();
			expected_q.push_back(r);
		endfunction

		function void compare(string name, logic [7:0] e, logic [7:0] g);
			if (g !== e) begin
				$error("%s: expected %0h, got %0h", name, e, g);
				errors++;
			end
		endfunction

		function void check_result(ows_pkg::res_t got);
			ows_pkg::res_t e;
			checked++;
			if (expected_q.size() == 0) begin
				$error("result transaction with nothing expected: %h", got);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			compare("send_valid", 8'(e.send_valid), 8'(got.send_valid));
			compare("send_byte", e.send_byte, got.send_byte);
			compare("reset_speed", 8'(e.reset_speed), 8'(got.reset_speed));
			compare("read_valid", 8'(e.read_valid), 8'(got.read_valid));
			compare("read_byte", e.read_byte, got.read_byte);
			compare("read_from_function", 8'(e.read_from_function),
				8'(got.read_from_function));
			compare("read_index", 8'(e.read_index), 8'(got.read_index));
			compare("done_res", 8'(e.done_res), 8'(got.done_res));
			compare("no_device", 8'(e.no_device), 8'(got.no_device));
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;

	onewire_scoreboard sb = new();
	bit steady_run;
	int tx_count;

	onewire_uart_transaction_sequencer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#1000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic logic [39:0] pack_item(ows_pkg::item_t it);
		return {4'b0, it.echo_byte, it.data_byte, it.load_index,
			it.func_cmd_byte, it.rom_cmd_byte};
	endfunction

	function automatic ows_pkg::item_t unpack_item(logic [39:0] d, logic [1:0] u);
		ows_pkg::item_t it;
		it.req_type      = u;
		it.rom_cmd_byte  = d[7:0];
		it.func_cmd_byte = d[15:8];
		it.load_index    = d[19:16];
		it.data_byte     = d[27:20];
		it.echo_byte     = d[35:28];
		return it;
	endfunction

	function automatic ows_pkg::res_t unpack_res(logic [31:0] d);
		ows_pkg::res_t r;
		r.send_valid         = d[0];
		r.send_byte          = d[8:1];
		r.reset_speed        = d[9];
		r.read_valid         = d[10];
		r.read_byte          = d[18:11];
		r.read_from_function = d[19];
		r.read_index         = d[23:20];
		r.done_res           = d[24];
		r.no_device          = d[25];
		return r;
	endfunction

	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic ows_pkg::item_t rand_item(logic [1:0] req);
		ows_pkg::item_t it;
		it.req_type      = req;
		it.rom_cmd_byte  = 8'($urandom);
		it.func_cmd_byte = 8'($urandom);
		it.load_index    = 4'($urandom);
		it.data_byte     = 8'($urandom);
		it.echo_byte     = 8'($urandom);
		return it;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_input(unpack_item(s_tdata, s_tuser));
			if (m_tvalid && m_tready)
				sb.check_result(unpack_res(m_tdata));
		end
	end

	// receiver side, with one long hold to back the block up
	initial begin
		int  gap;
		bit  long_hold_done;
		long_hold_done = 1'b0;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (!long_hold_done && sb.checked >= 150) begin
				long_hold_done = 1'b1;
				gap = 300;
			end else begin
				gap = draw_gap();
			end
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			if ($urandom_range(0, 9) == 0)
				repeat ($urandom_range(30, 80)) @(negedge clk);
			else
				repeat ($urandom_range(1, 8)) @(negedge clk);
		end
	end

	task automatic send_item(ows_pkg::item_t it);
		int gap;
		gap = steady_run ? 0 : draw_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= pack_item(it);
		s_tuser  <= it.req_type;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.expected_q.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic start_commands(inout ows_pkg::item_t it);
		int r;
		steady_run = ($urandom_range(0, 3) == 0);
		if (tx_count == 0) begin
			it.rom_cmd_byte  = ows_pkg::CMD_READ_ROM;
			it.func_cmd_byte = ows_pkg::CMD_READ_SP;
		end else if (tx_count == 1) begin
			it.rom_cmd_byte  = ows_pkg::CMD_MATCH_ROM;
			it.func_cmd_byte = ows_pkg::CMD_WRITE_SP;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 20) it.rom_cmd_byte = ows_pkg::CMD_READ_ROM;
			else if (r < 40) it.rom_cmd_byte = ows_pkg::CMD_MATCH_ROM;
			r = $urandom_range(0, 99);
			if (r < 25) it.func_cmd_byte = ows_pkg::CMD_WRITE_SP;
			else if (r < 45) it.func_cmd_byte = ows_pkg::CMD_READ_SP;
		end
		tx_count++;
	endtask

	task automatic pick_item(output ows_pkg::item_t it, output bit counts);
		int r;
		int e;
		r = $urandom_range(0, 99);
		counts = 1'b1;
		if (sb.phase == SEQ_IDLE) begin
			if (r < 4) begin
				it = rand_item(REQ_NONE);
				counts = 1'b0;
			end else if (r < 8) begin
				it = rand_item(ows_pkg::REQ_ECHO);
				counts = 1'b0;
			end else if (r < 18) begin
				it = rand_item(ows_pkg::REQ_LOAD);
				counts = (32'(it.load_index) < ows_pkg::STORE_DEPTH);
			end else begin
				it = rand_item(ows_pkg::REQ_START);
				start_commands(it);
			end
		end else if (r < 1) begin
			// restart in the middle of a transaction
			it = rand_item(ows_pkg::REQ_START);
			start_commands(it);
		end else if (r < 6) begin
			it = rand_item(ows_pkg::REQ_LOAD);
			counts = (32'(it.load_index) < ows_pkg::STORE_DEPTH);
		end else if (r < 8) begin
			it = rand_item(REQ_NONE);
			counts = 1'b0;
		end else begin
			it = rand_item(ows_pkg::REQ_ECHO);
			e = $urandom_range(0, 9);
			if (sb.phase == SEQ_PRESENCE) begin
				if (e == 0) it.echo_byte = ows_pkg::SLOT_RESET;
			end else if (e < 4) begin
				it.echo_byte = ows_pkg::SLOT_ONE;
			end else if (e < 7) begin
				it.echo_byte = ows_pkg::SLOT_ZERO;
			end
		end
	endtask

	initial begin
		ows_pkg::item_t it;
		int             useful;
		bit             paused;
		bit             counts;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= ows_pkg::REQ_START;
		steady_run = 1'b0;
		tx_count   = 0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// fill the whole write store first
		for (int i = 0; i < ows_pkg::STORE_DEPTH; i++) begin
			it = rand_item(ows_pkg::REQ_LOAD);
			it.load_index = 4'(i);
			if (i == 0) it.data_byte = 8'hFF;
			if (i == ows_pkg::STORE_DEPTH - 1) it.data_byte = 8'h00;
			send_item(it);
		end
		it = rand_item(ows_pkg::REQ_LOAD);
		it.load_index = 4'hF;
		send_item(it);
		send_item(rand_item(REQ_NONE));
		it = rand_item(ows_pkg::REQ_ECHO);
		it.echo_byte = ows_pkg::SLOT_ONE;
		send_item(it);

		// absent device
		send_item(rand_item(ows_pkg::REQ_START));
		it = rand_item(ows_pkg::REQ_ECHO);
		it.echo_byte = ows_pkg::SLOT_RESET;
		send_item(it);

		// plain commands, cut short by a fresh start
		it = rand_item(ows_pkg::REQ_START);
		it.rom_cmd_byte  = 8'hFF;
		it.func_cmd_byte = 8'h00;
		send_item(it);
		it = rand_item(ows_pkg::REQ_ECHO);
		it.echo_byte = ows_pkg::SLOT_ZERO;
		send_item(it);
		it.echo_byte = ows_pkg::SLOT_ONE;
		send_item(it);
		it.echo_byte = 8'h00;
		send_item(it);
		it = rand_item(ows_pkg::REQ_START);
		it.rom_cmd_byte  = ows_pkg::CMD_MATCH_ROM;
		it.func_cmd_byte = ows_pkg::CMD_READ_SP;
		send_item(it);

		useful = 0;
		paused = 1'b0;
		while (useful < 450) begin
			if (!paused && useful >= 200) begin
				paused = 1'b1;
				wait_drained();
			end
			pick_item(it, counts);
			if (counts) useful++;
			send_item(it);
		end
		wait_drained();

		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
